// ===== rtl/cinht_pkg.sv =====
// Shared types and constants for the case-insensitive name hash table.
// Holds the FSM state type, the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cinht_pkg;

    localparam int DEF_TABLE_SLOTS = 1024;
    localparam int DEF_MAX_ENTRIES = 512;
    localparam int DEF_NAME_LEN    = 64;

    localparam int STATUS_W = 3;
    localparam int IDX_W    = 9;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_REG_FULL   = 3'd4,
        ST_TABLE_FULL = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        IDX_ZERO,
        IDX_ENT,
        IDX_COUNT
    } idx_sel_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_WALK_RD,
        S_WALK_CHK,
        S_LEN_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_NEXT,
        S_FOUND,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_STORE_RD,
        S_STORE_WR,
        S_FIN,
        S_LINK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     clr_write;
        logic     take;
        logic     start_walk;
        logic     rd_slot_cur;
        logic     rd_slot_probe;
        logic     latch_ent;
        logic     pos_clear;
        logic     pos_inc;
        logic     follow_link;
        logic     probe_bucket;
        logic     probe_init;
        logic     probe_inc;
        logic     wr_name;
        logic     wr_entry;
        logic     wr_link;
        logic     set_result;
        status_t  res_status;
        idx_sel_t res_idx;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic last_fire;
        logic op_insert;
        logic qlen_zero;
        logic reg_full;
        logic slot_used;
        logic slot_linked;
        logic len_match;
        logic char_match;
        logic pos_last;
        logic probe_last;
        logic link;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/cinht_dp.sv =====
// Datapath of the name hash table: FNV-1a hash, query buffer, name store,
// slot table and result register. Driven by cinht_ctrl; uses cinht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cinht_dp
    import cinht_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int NAME_LEN    = DEF_NAME_LEN
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_opcode,
    input  wire logic [7:0]          s_name_char,
    input  wire logic                s_last_char,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [IDX_W-1:0]         m_entry_index,
    input  wire cmd_t                cmd,
    output sts_t                     sts
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int ENT_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = ENT_W + 1;
    localparam int POS_W   = $clog2(NAME_LEN);
    localparam int NADDR_W = $clog2(MAX_ENTRIES * NAME_LEN);
    localparam int WORD_W  = 2 + ENT_W + SLOT_W;

    typedef struct packed {
        logic              used;
        logic [ENT_W-1:0]  entry;
        logic              linked;
        logic [SLOT_W-1:0] next;
    } slot_word_t;

    // Memories.
    logic [7:0]       qbuf_mem [NAME_LEN];
    logic [7:0]       name_mem [MAX_ENTRIES * NAME_LEN];
    logic [POS_W-1:0] len_mem  [MAX_ENTRIES];
    slot_word_t       slot_mem [TABLE_SLOTS];

    logic [31:0]       hash_reg;
    logic [POS_W-1:0]  qlen_reg;
    logic              ended_reg;
    logic              op_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic [SLOT_W-1:0] probe_reg;
    logic [SLOT_W-1:0] pcnt_reg;
    logic              link_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic [POS_W-1:0]  pos_reg;
    slot_word_t        slot_rd_reg;
    logic [POS_W-1:0]  len_rd_reg;
    logic [7:0]        name_rd_reg;
    logic [7:0]        qbuf_rd_reg;
    status_t           res_status_reg;
    logic [ENT_W-1:0]  res_idx_reg;
    logic              m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [IDX_W-1:0]  m_index_reg;

    logic              fire;
    logic              keep_char;
    logic [7:0]        low_char;
    logic [31:0]       hash_next;
    logic [SLOT_W-1:0] slot_raddr;
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    slot_word_t        slot_wdata;
    logic [NADDR_W-1:0] name_raddr;
    logic [NADDR_W-1:0] name_waddr;
    logic [ENT_W-1:0]  res_idx_val;

    assign fire      = s_valid && cmd.take;
    assign keep_char = fire && !ended_reg && (s_name_char != 8'd0)
                       && (qlen_reg < POS_W'(NAME_LEN - 1));

    always_comb begin
        low_char = s_name_char;
        if (s_name_char inside {[8'h41:8'h5A]}) begin
            low_char = s_name_char + 8'd32;
        end
    end

    // One FNV-1a round: xor the byte, multiply by the prime modulo 2^32.
    assign hash_next = 32'((hash_reg ^ {24'd0, low_char}) * FNV_PRIME);

    assign slot_raddr = cmd.rd_slot_probe ? probe_reg : cur_reg;
    assign name_raddr = NADDR_W'(ent_reg) * NADDR_W'(NAME_LEN) + NADDR_W'(pos_reg);
    assign name_waddr = NADDR_W'(count_reg[ENT_W-1:0]) * NADDR_W'(NAME_LEN)
                        + NADDR_W'(pos_reg);

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = clr_reg;
        slot_wdata = slot_word_t'({WORD_W{1'b0}});
        if (cmd.clr_write) begin
            slot_we = 1'b1;
        end else if (cmd.wr_entry) begin
            slot_we           = 1'b1;
            slot_waddr        = probe_reg;
            slot_wdata.used   = 1'b1;
            slot_wdata.entry  = count_reg[ENT_W-1:0];
        end else if (cmd.wr_link) begin
            slot_we           = 1'b1;
            slot_waddr        = cur_reg;
            slot_wdata.used   = 1'b1;
            slot_wdata.entry  = ent_reg;
            slot_wdata.linked = 1'b1;
            slot_wdata.next   = probe_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (cmd.rd_slot_cur || cmd.rd_slot_probe) begin
            slot_rd_reg <= slot_mem[slot_raddr];
        end
        if (keep_char) begin
            qbuf_mem[qlen_reg] <= low_char;
        end
        qbuf_rd_reg <= qbuf_mem[pos_reg];
        if (cmd.wr_name) begin
            name_mem[name_waddr] <= qbuf_rd_reg;
        end
        name_rd_reg <= name_mem[name_raddr];
        if (cmd.wr_entry) begin
            len_mem[count_reg[ENT_W-1:0]] <= qlen_reg;
        end
        len_rd_reg <= len_mem[slot_rd_reg.entry];
    end

    always_comb begin
        case (cmd.res_idx)
            IDX_ENT:   res_idx_val = ent_reg;
            IDX_COUNT: res_idx_val = count_reg[ENT_W-1:0];
            default:   res_idx_val = '0;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg    <= FNV_BASIS;
            qlen_reg    <= '0;
            ended_reg   <= 1'b0;
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_write) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load_out) begin
                hash_reg  <= FNV_BASIS;
                qlen_reg  <= '0;
                ended_reg <= 1'b0;
            end else if (keep_char) begin
                hash_reg <= hash_next;
                qlen_reg <= qlen_reg + 1'b1;
            end else if (fire && !ended_reg && s_name_char == 8'd0) begin
                ended_reg <= 1'b1;
            end
            if (cmd.wr_entry) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Walk, probe and result registers.
    always_ff @(posedge aclk) begin
        if (fire && s_last_char) begin
            op_reg <= s_opcode;
        end
        if (cmd.start_walk) begin
            cur_reg <= hash_reg[SLOT_W-1:0];
        end else if (cmd.follow_link) begin
            cur_reg <= slot_rd_reg.next;
        end
        if (cmd.latch_ent) begin
            ent_reg <= slot_rd_reg.entry;
        end
        if (cmd.pos_clear) begin
            pos_reg <= '0;
        end else if (cmd.pos_inc) begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.probe_bucket) begin
            probe_reg <= cur_reg;
            link_reg  <= 1'b0;
        end else if (cmd.probe_init) begin
            probe_reg <= hash_reg[SLOT_W-1:0] + 1'b1;
            pcnt_reg  <= SLOT_W'(1);
            link_reg  <= 1'b1;
        end else if (cmd.probe_inc) begin
            probe_reg <= probe_reg + 1'b1;
            pcnt_reg  <= pcnt_reg + 1'b1;
        end
        if (cmd.set_result) begin
            res_status_reg <= cmd.res_status;
            res_idx_reg    <= res_idx_val;
        end
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= IDX_W'(res_idx_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_index = m_index_reg;

    assign sts.clr_last    = (clr_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign sts.last_fire   = fire && s_last_char;
    assign sts.op_insert   = op_reg;
    assign sts.qlen_zero   = (qlen_reg == '0);
    assign sts.reg_full    = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign sts.slot_used   = slot_rd_reg.used;
    assign sts.slot_linked = slot_rd_reg.linked;
    assign sts.len_match   = (len_rd_reg == qlen_reg);
    assign sts.char_match  = (name_rd_reg == qbuf_rd_reg);
    assign sts.pos_last    = (pos_reg == qlen_reg - 1'b1);
    assign sts.probe_last  = (pcnt_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign sts.link        = link_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;

    a_qlen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qlen_reg <= POS_W'(NAME_LEN - 1))
        else $error("query length beyond name limit");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond registry size");

    a_fail_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_OK |-> m_index_reg == '0)
        else $error("failed request carries a nonzero index");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_entry |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("entry count did not advance on insert");

endmodule

`default_nettype wire

// ===== rtl/cinht_ctrl.sv =====
// Controller state machine of the name hash table: clearing pass, character
// intake, chain walk, name compare, probing and store. Uses cinht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cinht_ctrl
    import cinht_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.take = 1'b1;
                if (sts.last_fire) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                if (sts.qlen_zero) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = sts.op_insert ? ST_EMPTY : ST_NOT_FOUND;
                    state_next     = S_DONE;
                end else if (sts.op_insert && sts.reg_full) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_REG_FULL;
                    state_next     = S_DONE;
                end else begin
                    cmd.start_walk = 1'b1;
                    state_next     = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                cmd.rd_slot_cur = 1'b1;
                state_next      = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (!sts.slot_used) begin
                    // Only the bucket slot itself can be empty on a walk.
                    if (sts.op_insert) begin
                        cmd.probe_bucket = 1'b1;
                        cmd.pos_clear    = 1'b1;
                        state_next       = S_STORE_RD;
                    end else begin
                        cmd.set_result = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                        state_next     = S_DONE;
                    end
                end else begin
                    cmd.latch_ent = 1'b1;
                    cmd.pos_clear = 1'b1;
                    state_next    = S_LEN_CHK;
                end
            end
            S_LEN_CHK: begin
                state_next = sts.len_match ? S_CMP_RD : S_NEXT;
            end
            S_CMP_RD: begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (!sts.char_match) begin
                    state_next = S_NEXT;
                end else if (sts.pos_last) begin
                    state_next = S_FOUND;
                end else begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_CMP_RD;
                end
            end
            S_NEXT: begin
                if (sts.slot_linked) begin
                    cmd.follow_link = 1'b1;
                    state_next      = S_WALK_RD;
                end else if (sts.op_insert) begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_PROBE_RD;
                end else begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_DONE;
                end
            end
            S_FOUND: begin
                cmd.set_result = 1'b1;
                if (sts.op_insert) begin
                    cmd.res_status = ST_DUPLICATE;
                end else begin
                    cmd.res_status = ST_OK;
                    cmd.res_idx    = IDX_ENT;
                end
                state_next = S_DONE;
            end
            S_PROBE_RD: begin
                cmd.rd_slot_probe = 1'b1;
                state_next        = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (!sts.slot_used) begin
                    cmd.pos_clear = 1'b1;
                    state_next    = S_STORE_RD;
                end else if (sts.probe_last) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = ST_TABLE_FULL;
                    state_next     = S_DONE;
                end else begin
                    cmd.probe_inc = 1'b1;
                    state_next    = S_PROBE_RD;
                end
            end
            S_STORE_RD: begin
                state_next = S_STORE_WR;
            end
            S_STORE_WR: begin
                cmd.wr_name = 1'b1;
                if (sts.pos_last) begin
                    state_next = S_FIN;
                end else begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_STORE_RD;
                end
            end
            S_FIN: begin
                cmd.wr_entry   = 1'b1;
                cmd.set_result = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_idx    = IDX_COUNT;
                state_next     = sts.link ? S_LINK : S_DONE;
            end
            S_LINK: begin
                cmd.wr_link = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.clr_write, cmd.wr_entry, cmd.wr_link}) <= 1)
        else $error("two slot writes in one cycle");

    a_link_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_link |-> $past(cmd.wr_entry))
        else $error("chain link written without a new entry");

    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.last_fire |=> state_reg == S_START)
        else $error("final character did not start a request");

endmodule

`default_nettype wire

// ===== rtl/case_insensitive_name_hash_table.sv =====
// Top level of the case-insensitive name hash table (FNV-1a, chained probing).
// Instantiates cinht_ctrl and cinht_dp; uses cinht_pkg.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   input   | s_valid s_ready s_opcode s_name_char s_last_char | in
//   result  | m_valid m_ready m_status m_entry_index       | out
//
// A character item that is not the last one is lowercased and folded into the
// hash; the hash round is one 32x32 multiply per cycle. A last character starts
// a request: a chain walk with a compare of each name of matching length, plus a
// probe for a free slot and a copy into the name store for an insert, paced by
// the registered slot table and name store reads. After reset a clearing pass
// empties every slot before the first item is accepted. A result waits in the output
// register while m_ready is low; the next request finishes only once it is taken.
`timescale 1ns / 1ps
`default_nettype none

module case_insensitive_name_hash_table
    import cinht_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int NAME_LEN    = DEF_NAME_LEN
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_opcode,
    input  wire logic [7:0]          s_name_char,
    input  wire logic                s_last_char,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [IDX_W-1:0]         m_entry_index
);

    cmd_t cmd;
    sts_t sts;

    // The controller only accepts characters while no request is in flight.
    assign s_ready = cmd.take;

    cinht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    cinht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .NAME_LEN    (NAME_LEN)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_opcode      (s_opcode),
        .s_name_char   (s_name_char),
        .s_last_char   (s_last_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_index (m_entry_index),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire
